### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

### rtl/fcl_pkg.sv
package fcl_pkg;
    localparam int MAX_IN       = 16;
    localparam int OUT_FEATURES = 16;
    localparam int IW = $clog2(MAX_IN);
    localparam int OW = $clog2(OUT_FEATURES);
    localparam int ACC_W = 40;
    localparam int DIGIT = 4;
    localparam int NDIG = 16 / DIGIT;

    typedef enum logic [1:0] {
        FN_WEIGHT = 2'd0,
        FN_BIAS   = 2'd1,
        FN_DATA   = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MAC,
        ST_OUT_RD,
        ST_OUT
    } t_state;

    localparam logic [0:0] REG_IN  = 1'd0;
    localparam logic [0:0] REG_OUT = 1'd1;

    function automatic logic [4:0] clamp_cnt(input logic [4:0] v, input logic [4:0] hi);
        if (v == 5'd0) return 5'd1;
        if (v > hi) return hi;
        return v;
    endfunction
endpackage

### rtl/fcl_serial_mac.sv
// Digit-serial signed 16x16 multiply-accumulate: one 4-bit digit of x per cycle.
module fcl_serial_mac
    import fcl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic signed [15:0]      i_x,
    input  logic signed [15:0]      i_w,
    input  logic signed [ACC_W-1:0] i_acc,
    output logic signed [ACC_W-1:0] o_acc
);
    logic [15:0]              r_x;
    logic signed [15:0]       r_w;
    logic [$clog2(NDIG)-1:0]  r_dig;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [20:0]       pp;
    logic signed [ACC_W-1:0]  pp_s;

    always_comb begin
        if (r_dig == NDIG - 1)
            pp = r_w * $signed({r_x[DIGIT-1], r_x[DIGIT-1:0]});
        else
            pp = r_w * $signed({1'b0, r_x[DIGIT-1:0]});
        pp_s = ACC_W'(pp) <<< (DIGIT * r_dig);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x   <= i_x;
            r_w   <= i_w;
            r_dig <= '0;
            r_acc <= i_acc;
        end else begin
            r_x   <= r_x >> DIGIT;
            r_dig <= r_dig + 1'b1;
            r_acc <= r_acc + pp_s;
        end
    end

    assign o_acc = r_acc;
endmodule

### rtl/fully_connected_layer.sv
// Dense layer, one beat per start pulse while busy is low. Weight and bias
// writes keep busy low, so they can follow every cycle. A data element whose
// column is below the active input count walks the active rows through one
// shared 4-bit digit-serial multiplier, row by row (weight and accumulator
// read, load, 4 digits, write back), with busy high throughout. The last element
// then emits one result per active row on o_valid strobes, with busy still high;
// the receiver cannot stall, results are presented once and must be taken.
`include "assert_macros.svh"
module fully_connected_layer
    import fcl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [3:0]         i_row,
    input  logic [3:0]         i_col,
    input  logic signed [15:0] i_value,
    output logic               o_valid,
    output logic [3:0]         o_out_index,
    output logic signed [31:0] o_out_value,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:2]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [15:0] r_wmem [MAX_IN*OUT_FEATURES];
    logic [15:0] r_bmem [OUT_FEATURES];
    logic signed [ACC_W-1:0] r_accm [OUT_FEATURES];
    logic [OUT_FEATURES-1:0] r_accv, n_accv;

    t_state r_state, n_state;
    logic [4:0] r_nin, r_nout;
    logic [OW-1:0] r_rowc, n_rowc;
    logic [IW-1:0] r_col;
    logic signed [15:0] r_x;
    logic [2:0] r_cnt, n_cnt;
    logic r_fin;
    logic [15:0] r_wrd, r_brd;
    logic signed [ACC_W-1:0] r_ard;
    logic mac_load;
    logic signed [ACC_W-1:0] mac_acc;
    logic [4:0] nin_c, nout_c;
    logic acc_we;
    logic accept;
    logic signed [ACC_W:0] sum;
    logic signed [31:0] sat;

    assign pready = 1'b1;
    assign prdata = {27'd0, (paddr[2] == REG_OUT) ? r_nout : r_nin};
    assign nin_c  = clamp_cnt(r_nin, 5'(MAX_IN));
    assign nout_c = clamp_cnt(r_nout, 5'(OUT_FEATURES));
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nin  <= 5'd16;
            r_nout <= 5'd16;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_IN) r_nin <= pwdata[4:0];
            else                    r_nout <= pwdata[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_func'(i_func) == FN_WEIGHT)
            r_wmem[{i_row, i_col}] <= i_value;
        if (accept && t_func'(i_func) == FN_BIAS)
            r_bmem[i_row] <= i_value;
        r_wrd <= r_wmem[{r_rowc, r_col}];
        r_brd <= r_bmem[r_rowc];
        r_ard <= r_accv[r_rowc] ? r_accm[r_rowc] : '0;
        if (acc_we)
            r_accm[r_rowc] <= mac_acc;
        if (accept) begin
            r_col <= i_col;
            r_x   <= i_value;
            r_fin <= ({1'b0, i_col} == nin_c - 5'd1);
        end
    end

    fcl_serial_mac u_mac (
        .i_clk (i_clk),
        .i_load(mac_load),
        .i_x   (r_x),
        .i_w   (r_wrd),
        .i_acc (r_ard),
        .o_acc (mac_acc)
    );

    always_comb begin
        sum = ACC_W'(r_ard) + ((ACC_W+1)'($signed(r_brd)) <<< 8);
        if (sum > 41'sd2147483647)       sat = 32'sh7fffffff;
        else if (sum < -41'sd2147483648) sat = 32'sh80000000;
        else                             sat = sum[31:0];
    end

    always_comb begin
        n_state = r_state;
        n_rowc = r_rowc;
        n_cnt = r_cnt;
        n_accv = r_accv;
        mac_load = 1'b0;
        acc_we = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_rowc = '0;
                if (accept && t_func'(i_func) == FN_DATA && {1'b0, i_col} < nin_c)
                    n_state = ST_RD;
            end
            ST_RD: begin
                n_cnt = '0;
                n_state = ST_MAC;
            end
            ST_MAC: begin
                n_cnt = r_cnt + 3'd1;
                mac_load = (r_cnt == 3'd0);
                if (r_cnt == 3'(NDIG + 1)) begin
                    acc_we = 1'b1;
                    n_accv[r_rowc] = 1'b1;
                    if ({1'b0, r_rowc} == nout_c - 5'd1) begin
                        n_rowc = '0;
                        n_state = r_fin ? ST_OUT_RD : ST_IDLE;
                    end else begin
                        n_rowc = r_rowc + 1'b1;
                        n_state = ST_RD;
                    end
                end
            end
            ST_OUT_RD: n_state = ST_OUT;
            ST_OUT: begin
                if ({1'b0, r_rowc} == nout_c - 5'd1) begin
                    n_accv = '0;
                    n_rowc = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_rowc = r_rowc + 1'b1;
                    n_state = ST_OUT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rowc  <= '0;
            r_cnt   <= '0;
            r_accv  <= '0;
        end else begin
            r_state <= n_state;
            r_rowc  <= n_rowc;
            r_cnt   <= n_cnt;
            r_accv  <= n_accv;
        end
    end

    assign o_valid     = (r_state == ST_OUT);
    assign o_out_index = r_rowc;
    assign o_out_value = sat;
    assign o_last      = o_valid && ({1'b0, r_rowc} == nout_c - 5'd1);

    `ASSERT_NEVER(a_out_idle, o_valid && (r_state == ST_IDLE), "result while idle")
    `ASSERT_IMPL(a_out_gap, o_valid |=> !o_valid, "back-to-back results")
    `ASSERT_IMPL(a_last_end, o_last |=> (r_state == ST_IDLE), "last not ending vector")
endmodule

### verif/tb_fully_connected_layer.sv
`timescale 1ns / 100ps

module tb_fully_connected_layer
    import fcl_pkg::*;
;

    typedef struct {
        logic [3:0]         index;
        logic signed [31:0] value;
        logic               last;
    } t_neuron_out;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_func;
    logic [3:0]         i_row;
    logic [3:0]         i_col;
    logic signed [15:0] i_value;
    logic               o_valid;
    logic [3:0]         o_out_index;
    logic signed [31:0] o_out_value;
    logic               o_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:2]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    fully_connected_layer uut (.*);

    // predictor state
    logic signed [15:0] wgt_mem [OUT_FEATURES][MAX_IN];
    logic signed [15:0] bias_mem [OUT_FEATURES];
    logic signed [39:0] acc_mem [OUT_FEATURES];
    logic [4:0]         n_in_reg;
    logic [4:0]         n_out_reg;
    t_neuron_out        pending_outs [$];

    int  n_errors;
    int  n_beats;
    int  n_outs;
    bit  gaps_on;

    localparam int SETTLE = 7 * OUT_FEATURES + 60;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int eff_count(input logic [4:0] v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic run_dense(input logic [1:0] fn, input logic [3:0] r, input logic [3:0] c,
                             input logic signed [15:0] x);
        int ni;
        int no;
        logic signed [63:0] s;
        t_neuron_out e;
        ni = eff_count(n_in_reg, MAX_IN);
        no = eff_count(n_out_reg, OUT_FEATURES);
        case (fn)
            FN_WEIGHT: wgt_mem[r][c] = x;
            FN_BIAS:   bias_mem[r] = x;
            FN_DATA: begin
                if (c < ni) begin
                    for (int k = 0; k < no; k++)
                        acc_mem[k] = acc_mem[k] + 40'(signed'(32'(x * wgt_mem[k][c])));
                    if (c == ni - 1) begin
                        for (int k = 0; k < no; k++) begin
                            s = 64'(acc_mem[k]) + (64'(bias_mem[k]) <<< 8);
                            if (s > 64'sh7FFFFFFF) s = 64'sh7FFFFFFF;
                            if (s < -64'sh80000000) s = -64'sh80000000;
                            e.index = 4'(k);
                            e.value = s[31:0];
                            e.last  = (k == no - 1);
                            pending_outs = {pending_outs, e};
                        end
                        for (int k = 0; k < OUT_FEATURES; k++) acc_mem[k] = '0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            n_beats++;
            run_dense(i_func, i_row, i_col, i_value);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_outs++;
            if (pending_outs.size() == 0) begin
                $display("%0t: unexpected result idx=%0d val=%0d last=%0b",
                         $time, o_out_index, o_out_value, o_last);
                n_errors++;
            end else begin
                t_neuron_out e;
                e = pending_outs.pop_front();
                if (o_out_index !== e.index || o_out_value !== e.value
                        || o_last !== e.last) begin
                    $display("%0t: mismatch exp idx=%0d val=%0d last=%0b, got idx=%0d val=%0d last=%0b",
                             $time, e.index, e.value, e.last,
                             o_out_index, o_out_value, o_last);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_beat(input logic [1:0] fn, input logic [3:0] r, input logic [3:0] c,
                             input logic signed [15:0] x);
        if (gaps_on && $urandom_range(99) < 26) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_func  <= fn;
        i_row   <= r;
        i_col   <= c;
        i_value <= x;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_outs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= idx;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IN) n_in_reg = val[4:0];
        else n_out_reg = val[4:0];
    endtask

    task automatic send_vector(input bit extremes);
        int ni;
        logic signed [15:0] x;
        ni = eff_count(n_in_reg, MAX_IN);
        for (int c = 0; c < ni; c++) begin
            x = extremes ? (($urandom_range(1)) ? 16'sh7FFF : -16'sh8000) : 16'($urandom);
            send_beat(FN_DATA, 4'($urandom), 4'(c), x);
        end
    endtask

    task automatic test_load_stores();
        for (int r = 0; r < OUT_FEATURES; r++) begin
            send_beat(FN_BIAS, 4'(r), 4'($urandom), 16'($urandom));
            for (int c = 0; c < MAX_IN; c++)
                send_beat(FN_WEIGHT, 4'(r), 4'(c), 16'($urandom));
        end
    endtask

    task automatic test_directed();
        send_beat(FN_NONE, 4'hF, 4'hF, 16'sh7FFF);
        send_vector(1'b0);
        write_reg(REG_IN, 32'd3);
        write_reg(REG_OUT, 32'd2);
        send_beat(FN_DATA, 4'd9, 4'd12, 16'sh1234);
        send_beat(FN_DATA, 4'd0, 4'd1, -16'sh8000);
        send_beat(FN_DATA, 4'd0, 4'd1, 16'sh7FFF);
        send_beat(FN_DATA, 4'd0, 4'd0, 16'sh0001);
        send_beat(FN_DATA, 4'd0, 4'd2, 16'shFFFF);
        send_beat(FN_DATA, 4'd0, 4'd2, 16'sh0000);
        write_reg(REG_IN, 32'hFFFF_FFE0);
        write_reg(REG_OUT, 32'd31);
        send_beat(FN_DATA, 4'd0, 4'd0, 16'sh0100);
        write_reg(REG_IN, 32'd1);
        write_reg(REG_OUT, 32'd16);
        send_beat(FN_DATA, 4'd0, 4'd0, -16'sh0100);
        send_beat(FN_DATA, 4'd5, 4'd15, 16'sh0100);
    endtask

    task automatic test_saturation();
        write_reg(REG_IN, 32'd16);
        write_reg(REG_OUT, 32'd4);
        for (int c = 0; c < MAX_IN; c++) begin
            send_beat(FN_WEIGHT, 4'd0, 4'(c), 16'sh7FFF);
            send_beat(FN_WEIGHT, 4'd1, 4'(c), -16'sh8000);
        end
        send_beat(FN_BIAS, 4'd0, 4'd0, 16'sh7FFF);
        send_beat(FN_BIAS, 4'd1, 4'd0, -16'sh8000);
        for (int c = 0; c < MAX_IN; c++)
            send_beat(FN_DATA, 4'd0, 4'(c), 16'sh7FFF);
        send_vector(1'b1);
    endtask

    task automatic test_random();
        int sent;
        int pick;
        logic [31:0] cfg_pick [6];
        cfg_pick = '{32'd16, 32'd1, 32'd0, 32'd31, 32'd7, 32'd12};
        sent = 0;
        for (int ph = 0; ph < 8; ph++) begin
            gaps_on = (ph != 3);
            if (ph < 6) begin
                write_reg(REG_IN, (cfg_pick[ph] & 32'h1F) | ($urandom << 5));
                write_reg(REG_OUT, cfg_pick[(ph + 2) % 6]);
            end else begin
                write_reg(REG_IN, $urandom_range(1, 16));
                write_reg(REG_OUT, $urandom_range(1, 16));
            end
            while (sent < (ph + 1) * 18) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    send_vector(1'b0);
                    sent += eff_count(n_in_reg, MAX_IN);
                end else if (pick < 85) begin
                    send_beat(2'($urandom_range(1)), 4'($urandom), 4'($urandom),
                              16'($urandom));
                    sent++;
                end else if (pick < 95) begin
                    send_beat(FN_DATA, 4'($urandom), 4'($urandom), 16'($urandom));
                    sent++;
                end else begin
                    send_beat(FN_NONE, 4'($urandom), 4'($urandom), 16'($urandom));
                end
            end
            if (ph == 4) drain();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_func  = FN_NONE;
        i_row   = '0;
        i_col   = '0;
        i_value = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        n_errors = 0;
        n_beats  = 0;
        n_outs   = 0;
        gaps_on  = 1'b1;
        n_in_reg  = 5'd16;
        n_out_reg = 5'd16;
        for (int k = 0; k < OUT_FEATURES; k++) acc_mem[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_load_stores();
        test_directed();
        test_saturation();
        test_random();
        drain();

        $display("Covered %0d accepted beats and %0d results: store loads, saturation,",
                 n_beats, n_outs);
        $display("clamped counts, ignored codes and random vectors.");
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout, %0d results still expected", pending_outs.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/fcl_pkg.sv
rtl/fcl_serial_mac.sv
rtl/fully_connected_layer.sv
verif/tb_fully_connected_layer.sv
